// File: design/btok_pkg.sv
// Package: shared types, constants and byte classes of the byte stream tokenizer
`timescale 1ns / 1ps
package btok_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [KindW-1:0] {
    KindByte      = 2'd0,
    KindTokenEnd  = 2'd1,
    KindStreamEnd = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteDouble = 2'd1,
    QuoteSingle = 2'd2
  } quote_e;

  localparam logic [CfgIdxW-1:0] CfgDoubleQuote = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgSingleQuote = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgEscape      = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxLength   = 8'd3;

  localparam logic [ByteW-1:0] ChNul    = 8'h00;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChDquote = 8'h22;
  localparam logic [ByteW-1:0] ChSquote = 8'h27;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;

  // Results caused by one item, emitted in field order
  typedef struct packed {
    logic             pre_end;
    logic [ByteW-1:0] pre_len;
    logic             byte_vld;
    logic [ByteW-1:0] byte_val;
    logic             post_end;
    logic [ByteW-1:0] post_len;
    logic             stream_end;
  } pkt_t;

  function automatic logic is_space(input logic [ByteW-1:0] b);
    return (b == ChNul) || (b == ChSpace) || (b == ChTab) || (b == ChLf) || (b == ChCr);
  endfunction

  function automatic logic is_punct(input logic [ByteW-1:0] b);
    logic r;
    unique case (b)
      8'h00, 8'h7B, 8'h7D, 8'h3B, 8'h2E, 8'h5B, 8'h5D, 8'h3C,
      8'h3E, 8'h2A, 8'h2C, 8'h28, 8'h29, 8'h23, 8'h2B, 8'h3D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: design/btok_intf.sv
// Interfaces: input, configuration and result channels
`timescale 1ns / 1ps
interface btok_in_if;
  logic                        valid;
  logic                        ready;
  logic [btok_pkg::ByteW-1:0]  input_byte;
  logic                        end_of_input;
  modport source (output valid, output input_byte, output end_of_input, input ready);
  modport sink (input valid, input input_byte, input end_of_input, output ready);
endinterface

interface btok_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [btok_pkg::CfgIdxW-1:0] index;
  logic [btok_pkg::ByteW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface btok_out_if;
  logic                        valid;
  logic                        ready;
  logic [btok_pkg::KindW-1:0]  result_kind;
  logic [btok_pkg::ByteW-1:0]  token_byte;
  logic [btok_pkg::ByteW-1:0]  token_length;
  logic                        last;
  modport source (output valid, output result_kind, output token_byte,
                  output token_length, output last, input ready);
  modport sink (input valid, input result_kind, input token_byte,
                input token_length, input last, output ready);
endinterface

// File: design/btok_front.sv
// Front end: configuration registers, byte classification and token state
`timescale 1ns / 1ps
module btok_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  btok_in_if.sink        in_i,
  btok_cfg_if.sink       cfg_i,
  input  logic           full_i,
  output logic           push_o,
  output btok_pkg::pkt_t pkt_o
);

  logic                       dq_en_q;
  logic                       sq_en_q;
  logic                       esc_en_q;
  logic [btok_pkg::ByteW-1:0] max_len_q;

  btok_pkg::quote_e           quote_q, quote_d;
  logic                       esc_q, esc_d;
  logic [btok_pkg::ByteW-1:0] cnt_q, cnt_d;

  logic accept;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !full_i;
  assign accept      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_en_q   <= 1'b1;
      sq_en_q   <= 1'b1;
      esc_en_q  <= 1'b1;
      max_len_q <= 8'd255;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == btok_pkg::CfgDoubleQuote) dq_en_q <= cfg_i.data[0];
      if (cfg_i.index == btok_pkg::CfgSingleQuote) sq_en_q <= cfg_i.data[0];
      if (cfg_i.index == btok_pkg::CfgEscape)      esc_en_q <= cfg_i.data[0];
      if (cfg_i.index == btok_pkg::CfgMaxLength)   max_len_q <= cfg_i.data;
    end
  end

  always_comb begin
    logic                       b_space;
    logic                       b_special;
    logic                       skip;
    logic [btok_pkg::ByteW-1:0] limit;
    logic [btok_pkg::ByteW-1:0] b;
    b         = in_i.input_byte;
    b_space   = btok_pkg::is_space(b);
    b_special = btok_pkg::is_punct(b);
    limit     = (max_len_q == '0) ? 8'd1 : max_len_q;
    skip      = 1'b0;
    pkt_o     = '0;
    quote_d   = quote_q;
    esc_d     = esc_q;
    cnt_d     = cnt_q;
    if (in_i.end_of_input) begin
      pkt_o.pre_end    = (cnt_q != '0);
      pkt_o.pre_len    = cnt_q;
      pkt_o.stream_end = 1'b1;
      quote_d          = btok_pkg::QuoteNone;
      esc_d            = 1'b0;
      cnt_d            = '0;
    end else begin
      if (!esc_q) begin
        if (b_space && cnt_q != '0 && quote_q == btok_pkg::QuoteNone) begin
          pkt_o.pre_end = 1'b1;
          pkt_o.pre_len = cnt_q;
          cnt_d         = '0;
          esc_d         = 1'b0;
          skip          = 1'b1;
        end else if (b_space && cnt_q == '0) begin
          skip = 1'b1;
        end else begin
          if (cnt_q != '0 && b_special && quote_q == btok_pkg::QuoteNone) begin
            pkt_o.pre_end = 1'b1;
            pkt_o.pre_len = cnt_q;
            cnt_d         = '0;
          end
          if (dq_en_q && b == btok_pkg::ChDquote && quote_q == btok_pkg::QuoteNone) begin
            quote_d = btok_pkg::QuoteDouble;
          end else if (sq_en_q && b == btok_pkg::ChSquote &&
                       quote_q == btok_pkg::QuoteNone) begin
            quote_d = btok_pkg::QuoteSingle;
          end else if ((quote_q == btok_pkg::QuoteDouble && b == btok_pkg::ChDquote) ||
                       (quote_q == btok_pkg::QuoteSingle && b == btok_pkg::ChSquote)) begin
            quote_d = btok_pkg::QuoteNone;
          end
        end
      end
      if (!skip) begin
        if (cnt_d < limit) begin
          pkt_o.byte_vld = 1'b1;
          pkt_o.byte_val = b;
          cnt_d          = 8'(cnt_d + 8'd1);
        end
        if (b_special && quote_d == btok_pkg::QuoteNone) begin
          pkt_o.post_end = 1'b1;
          pkt_o.post_len = cnt_d;
          cnt_d          = '0;
          quote_d        = btok_pkg::QuoteNone;
          esc_d          = 1'b0;
        end else if (!esc_q) begin
          esc_d = esc_en_q && (b == btok_pkg::ChBslash);
        end else begin
          esc_d = 1'b0;
        end
      end
    end
  end

  assign push_o = accept && (pkt_o.pre_end || pkt_o.byte_vld || pkt_o.post_end ||
                             pkt_o.stream_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q <= btok_pkg::QuoteNone;
      esc_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (accept) begin
      quote_q <= quote_d;
      esc_q   <= esc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: design/btok_fifo.sv
// Queue of result groups between front end and back end
`timescale 1ns / 1ps
module btok_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  btok_pkg::pkt_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output btok_pkg::pkt_t data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  btok_pkg::pkt_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue lost an item");
`endif

endmodule

// File: design/btok_back.sv
// Back end: emit the results of each queued group through an output register
`timescale 1ns / 1ps
module btok_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  btok_pkg::pkt_t pkt_i,
  output logic           pop_o,
  btok_out_if.source     out_o
);

  logic [3:0] done_q, done_d;
  logic [3:0] pend;
  logic [3:0] sel;
  logic [3:0] rest;
  logic       load;
  logic       emit;
  logic       is_last;

  logic                        vld_q;
  btok_pkg::kind_e             kind_q, kind_d;
  logic [btok_pkg::ByteW-1:0]  byte_q, byte_d;
  logic [btok_pkg::ByteW-1:0]  len_q, len_d;
  logic                        last_q;

  assign pend    = {pkt_i.stream_end, pkt_i.post_end, pkt_i.byte_vld, pkt_i.pre_end} & ~done_q;
  assign sel     = pend & (~pend + 4'd1);
  assign rest    = pend & ~sel;
  assign is_last = (rest == '0);
  assign load    = !vld_q || out_o.ready;
  assign emit    = load && !empty_i;
  assign pop_o   = emit && is_last;

  always_comb begin
    kind_d = btok_pkg::KindStreamEnd;
    byte_d = '0;
    len_d  = '0;
    priority if (sel[0]) begin
      kind_d = btok_pkg::KindTokenEnd;
      len_d  = pkt_i.pre_len;
    end else if (sel[1]) begin
      kind_d = btok_pkg::KindByte;
      byte_d = pkt_i.byte_val;
    end else if (sel[2]) begin
      kind_d = btok_pkg::KindTokenEnd;
      len_d  = pkt_i.post_len;
    end else begin
      kind_d = btok_pkg::KindStreamEnd;
    end
    done_d = done_q;
    if (emit) begin
      done_d = is_last ? 4'b0000 : (done_q | sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= '0;
    end else begin
      done_q <= done_d;
      if (load) begin
        vld_q <= !empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      len_q  <= len_d;
      last_q <= is_last;
    end
  end

  assign out_o.valid        = vld_q;
  assign out_o.result_kind  = kind_q;
  assign out_o.token_byte   = byte_q;
  assign out_o.token_length = len_q;
  assign out_o.last         = last_q;

endmodule

// File: design/byte_stream_tokenizer.sv
// Top level: byte stream tokenizer
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    input_byte, end_of_input
//   cfg_i    in   valid / ready    index, data
//   out_o    out  valid / ready    result_kind, token_byte, token_length, last
//
// One input item is classified and the token state updated in the cycle it is
// accepted; an item can be taken every cycle while the result queue has room.
// Results leave through a registered output, one per cycle while out_o is ready, 0 to 3 per item,
// so sustained input rate is bounded by the output port at one result a cycle.
// Reset clears the token state, the queue and the output register, and sets
// the configuration registers to their defaults. cfg_i is always ready.
`timescale 1ns / 1ps
module byte_stream_tokenizer #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  btok_in_if.sink    in_i,
  btok_cfg_if.sink   cfg_i,
  btok_out_if.source out_o
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  btok_pkg::pkt_t pkt_wr;
  btok_pkg::pkt_t pkt_rd;

  btok_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .pkt_o  (pkt_wr)
  );

  btok_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (pkt_wr),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pkt_rd),
    .empty_o (empty)
  );

  btok_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .pkt_i   (pkt_rd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: bench/testbench.sv
// Testbench: directed and random text through the byte stream tokenizer, results checked
`timescale 1ns / 1ps
module testbench;
  import btok_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 8'd4;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned ItemsPerPhase = 44;
  localparam int DirectedRows = 27;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] tok_byte;
    logic [ByteW-1:0] tok_len;
    logic             last;
  } token_res_t;

  // n_fixed: -1 takes the prediction, 0 or 1 gives the typed-in results
  typedef struct {
    logic [ByteW-1:0] b;
    logic             eoi;
    int               n_fixed;
    kind_e            kind;
    logic [ByteW-1:0] fix_byte;
    logic [ByteW-1:0] fix_len;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic quiet = 1'b0;
  int   bad_count = 0;

  token_res_t expected_q[$];

  // token state and register copies
  quote_e           quote_st;
  logic             esc_st;
  logic [ByteW-1:0] tok_len;
  logic             dq_en;
  logic             sq_en;
  logic             esc_en;
  logic [ByteW-1:0] max_len;

  btok_in_if  in_if();
  btok_cfg_if cfg_if();
  btok_out_if out_if();

  byte_stream_tokenizer dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  always #10 clk = ~clk;

  stim_row_t script [DirectedRows] = '{
    '{"a",      1'b0,  1, KindByte,      "a",   8'd0},
    '{8'hFF,    1'b0,  1, KindByte,      8'hFF, 8'd0},
    '{ChSpace,  1'b0,  1, KindTokenEnd,  8'd0,  8'd2},
    '{ChTab,    1'b0,  0, KindByte,      8'd0,  8'd0},
    '{"(",      1'b0, -1, KindByte,      8'd0,  8'd0},
    '{"x",      1'b0, -1, KindByte,      8'd0,  8'd0},
    '{";",      1'b0, -1, KindByte,      8'd0,  8'd0},
    '{"y",      1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChNul,    1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChNul,    1'b0,  0, KindByte,      8'd0,  8'd0},
    '{ChDquote, 1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChSpace,  1'b0, -1, KindByte,      8'd0,  8'd0},
    '{";",      1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChDquote, 1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChLf,     1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChSquote, 1'b0, -1, KindByte,      8'd0,  8'd0},
    '{"q",      1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChBslash, 1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChSquote, 1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChSquote, 1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChCr,     1'b0, -1, KindByte,      8'd0,  8'd0},
    '{ChBslash, 1'b0, -1, KindByte,      8'd0,  8'd0},
    '{".",      1'b0, -1, KindByte,      8'd0,  8'd0},
    '{"z",      1'b0, -1, KindByte,      8'd0,  8'd0},
    '{8'hFF,    1'b1, -1, KindByte,      8'd0,  8'd0},
    '{8'h00,    1'b1,  1, KindStreamEnd, 8'd0,  8'd0},
    '{ChDquote, 1'b0, -1, KindByte,      8'd0,  8'd0}
  };

  function automatic logic is_blank(logic [ByteW-1:0] b);
    case (b)
      ChNul, ChSpace, ChTab, ChLf, ChCr: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_delim(logic [ByteW-1:0] b);
    case (b)
      ChNul, "{", "}", ";", ".", "[", "]", "<", ">", "*", ",", "(", ")", "#", "+", "=":
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void emit(kind_e k, logic [ByteW-1:0] b, logic [ByteW-1:0] l);
    token_res_t r;
    r.kind = k;
    r.tok_byte = b;
    r.tok_len = l;
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void close_token();
    emit(KindTokenEnd, 8'd0, tok_len);
    tok_len = 8'd0;
    quote_st = QuoteNone;
    esc_st = 1'b0;
  endfunction

  function automatic void predict_tokens(logic [ByteW-1:0] b, logic eoi);
    logic [ByteW-1:0] cap;
    logic was_esc;
    int base;
    token_res_t tail;
    base = expected_q.size();
    cap = (max_len == 8'd0) ? 8'd1 : max_len;
    if (eoi) begin
      if (tok_len != 8'd0) close_token();
      emit(KindStreamEnd, 8'd0, 8'd0);
      quote_st = QuoteNone;
      esc_st = 1'b0;
      tok_len = 8'd0;
    end else begin
      was_esc = esc_st;
      if (!was_esc && is_blank(b) && (tok_len == 8'd0 || quote_st == QuoteNone)) begin
        if (tok_len != 8'd0) close_token();
      end else begin
        if (!was_esc) begin
          if (tok_len != 8'd0 && is_delim(b) && quote_st == QuoteNone) close_token();
          if (dq_en && b == ChDquote && quote_st == QuoteNone) begin
            quote_st = QuoteDouble;
          end else if (sq_en && b == ChSquote && quote_st == QuoteNone) begin
            quote_st = QuoteSingle;
          end else if ((quote_st == QuoteDouble && b == ChDquote) ||
                       (quote_st == QuoteSingle && b == ChSquote)) begin
            quote_st = QuoteNone;
          end
        end
        if (tok_len < cap) begin
          emit(KindByte, b, 8'd0);
          tok_len = tok_len + 8'd1;
        end
        if (is_delim(b) && quote_st == QuoteNone) begin
          close_token();
        end else if (!was_esc) begin
          esc_st = esc_en && (b == ChBslash);
        end else begin
          esc_st = 1'b0;
        end
      end
    end
    if (expected_q.size() > base) begin
      tail = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endfunction

  function automatic void set_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] d);
    case (idx)
      CfgDoubleQuote: dq_en = d[0];
      CfgSingleQuote: sq_en = d[0];
      CfgEscape:      esc_en = d[0];
      CfgMaxLength:   max_len = d;
      default: ;
    endcase
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int in_gap();
    if (quiet || $urandom_range(0, 99) >= 30) return 0;
    return idle_len();
  endfunction

  function automatic logic [ByteW-1:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'("a" + $urandom_range(0, 25));
    if (r < 45) return 8'("0" + $urandom_range(0, 9));
    if (r < 58) begin
      case ($urandom_range(0, 9))
        0:       return ChNul;
        1, 2:    return ChTab;
        3:       return ChLf;
        4:       return ChCr;
        default: return ChSpace;
      endcase
    end
    if (r < 72) begin
      case ($urandom_range(0, 14))
        0:  return "{";
        1:  return "}";
        2:  return ";";
        3:  return ".";
        4:  return "[";
        5:  return "]";
        6:  return "<";
        7:  return ">";
        8:  return "*";
        9:  return ",";
        10: return "(";
        11: return ")";
        12: return "#";
        13: return "+";
        default: return "=";
      endcase
    end
    if (r < 80) return ChDquote;
    if (r < 86) return ChSquote;
    if (r < 91) return ChBslash;
    return 8'($urandom);
  endfunction

  task automatic send_item(logic [ByteW-1:0] b, logic eoi);
    int gap;
    gap = in_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.input_byte <= b;
    in_if.end_of_input <= eoi;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    do @(posedge clk); while (!cfg_if.ready);
    set_reg(idx, d);
  endtask

  // flags carry random upper bits, which the block ignores
  task automatic configure(logic dq, logic sq, logic esc, logic [ByteW-1:0] ml);
    write_reg(CfgDoubleQuote, {7'($urandom), dq});
    write_reg(CfgSingleQuote, {7'($urandom), sq});
    write_reg(CfgUnused, 8'($urandom));
    write_reg(CfgEscape, {7'($urandom), esc});
    write_reg(CfgMaxLength, ml);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin : calm_switch
    int calm_left;
    calm_left = 100;
    forever begin
      @(posedge clk);
      if (calm_left == 0) begin
        calm_left = quiet ? $urandom_range(150, 500) : $urandom_range(40, 160);
        quiet <= !quiet;
      end else begin
        calm_left--;
      end
    end
  end

  initial begin : sink_pace
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        hold_left = idle_len() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    token_res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected result kind=%0d byte=%02h len=%0d last=%0b", $realtime,
                   out_if.result_kind, out_if.token_byte, out_if.token_length, out_if.last);
      end else begin
        want = expected_q.pop_front();
        if (out_if.result_kind !== want.kind || out_if.token_byte !== want.tok_byte ||
            out_if.token_length !== want.tok_len || out_if.last !== want.last) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: mismatch kind=%0d/%0d byte=%02h/%02h len=%0d/%0d last=%0b/%0b",
                     $realtime, out_if.result_kind, want.kind, out_if.token_byte,
                     want.tok_byte, out_if.token_length, want.tok_len, out_if.last, want.last);
        end
      end
    end
  end

  initial begin : stimulus
    int base;
    logic [ByteW-1:0] b;
    logic eoi;
    token_res_t fixed;
    in_if.valid <= 1'b0;
    in_if.input_byte <= 8'd0;
    in_if.end_of_input <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CfgDoubleQuote;
    cfg_if.data <= 8'd0;
    quote_st = QuoteNone;
    esc_st = 1'b0;
    tok_len = 8'd0;
    dq_en = 1'b1;
    sq_en = 1'b1;
    esc_en = 1'b1;
    max_len = 8'd255;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirectedRows; i++) begin
      send_item(script[i].b, script[i].eoi);
      base = expected_q.size();
      predict_tokens(script[i].b, script[i].eoi);
      if (script[i].n_fixed >= 0) begin
        while (expected_q.size() > base) void'(expected_q.pop_back());
        if (script[i].n_fixed == 1) begin
          fixed.kind = script[i].kind;
          fixed.tok_byte = script[i].fix_byte;
          fixed.tok_len = script[i].fix_len;
          fixed.last = 1'b1;
          expected_q.push_back(fixed);
        end
      end
    end

    // the string left open above must still close with quotes disabled
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: configure(1'b0, 1'b0, 1'b0, 8'd1);
        1: configure(1'b1, 1'b0, 1'b1, 8'd3);
        2: configure(1'b0, 1'b1, 1'b0, 8'd0);
        3: configure(1'b1, 1'b1, 1'b1, 8'd6);
        4: configure(1'b1, 1'b1, 1'b0, 8'd255);
        5: configure(1'b1, 1'b1, 1'b1, 8'd255);
        6: configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 8'($urandom_range(1, 12)));
        default: configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 8'($urandom));
      endcase
      repeat (ItemsPerPhase) begin
        eoi = ($urandom_range(0, 99) < 3);
        b = eoi ? 8'($urandom) : text_byte();
        send_item(b, eoi);
        predict_tokens(b, eoi);
      end
    end

    in_if.valid <= 1'b0;
    for (int n = 0; n < 20000 && expected_q.size() != 0; n++) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    bad_count += expected_q.size();
    if (bad_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
